@@ rtl/core/cca_pkg.sv @@
// ---------------------------------------------------------------------------
// Chunk allocator package
// Shared codes, widths, reset values and the control structs that pass
// between the top level and the per-class occupancy maps.
// ---------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

  // Field widths.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Default slot counts per class.
  localparam int unsigned SMALL_CHUNKS_DEF  = 16;
  localparam int unsigned MEDIUM_CHUNKS_DEF = 16;
  localparam int unsigned LARGE_CHUNKS_DEF  = 16;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACCESS  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_KEY   = 2'd3;

  // Class codes.
  localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SMALL  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_MEDIUM = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_LARGE  = 2'd3;

  // Key layout.
  localparam logic [KEY_W-1:0] KEY_NULL    = 16'hFFFF;
  localparam logic [KEY_W-1:0] CLASS_BIT_S = 16'h8000;
  localparam logic [KEY_W-1:0] CLASS_BIT_M = 16'h4000;
  localparam logic [KEY_W-1:0] CLASS_BIT_L = 16'h2000;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BYTES  = 2'd2;
  localparam logic [BYTES_W-1:0] SMALL_BYTES_RST  = 16'd16;
  localparam logic [BYTES_W-1:0] MEDIUM_BYTES_RST = 16'd64;
  localparam logic [BYTES_W-1:0] LARGE_BYTES_RST  = 16'd256;

  // Command into one occupancy map.
  typedef struct packed {
    logic               claim;
    logic               drop;
    logic [INDEX_W-1:0] drop_idx;
  } pool_cmd_t;

  // Status out of one occupancy map.
  typedef struct packed {
    logic               any_free;
    logic [INDEX_W-1:0] free_idx;
  } pool_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cca_pool_map.sv @@
// ---------------------------------------------------------------------------
// Chunk allocator occupancy map
// One used bit per slot of a class, with a find-first-free encoder that
// reports the lowest free slot. Claim marks that slot used; drop frees one.
// ---------------------------------------------------------------------------
`default_nettype none

module cca_pool_map #(
  parameter int unsigned CHUNKS = cca_pkg::SMALL_CHUNKS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cca_pkg::pool_cmd_t  cmd,
  output cca_pkg::pool_stat_t stat
);

  localparam int unsigned IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [CHUNKS-1:0] used;
  logic              found;
  logic [IDX_W-1:0]  first_free;

  // Lowest free slot: scan from the top so the lowest hit is kept.
  always_comb begin
    found      = 1'b0;
    first_free = '0;
    for (int i = int'(CHUNKS) - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found      = 1'b1;
        first_free = IDX_W'(i);
      end
    end
  end

  assign stat.any_free = found;
  assign stat.free_idx = cca_pkg::INDEX_W'(first_free);

  // Occupancy update; the caller only claims when a slot is free and only
  // drops indexes already checked against the slot count.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (cmd.claim) begin
        used[first_free] <= 1'b1;
      end
      if (cmd.drop) begin
        used[cmd.drop_idx[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/three_class_chunk_allocator_unit.sv @@
// A beat accepted on the input waits in the input register and moves on to the
// output register whenever it is free or being emptied. Throughput: one beat per
// cycle unless the output stalls; the occupancy maps are updated and searched in
// the same cycle, so back-to-back reserve and free beats see each other.
// Reset (synchronous, active high) frees every slot of all three classes,
// restores the chunk sizes to 16, 64 and 256 bytes and empties the pipeline.
// ---------------------------------------------------------------------------
// Three-class chunk allocator
// Fixed-size pool allocator with small, medium and large classes. Reserve
// claims the lowest free slot of the smallest fitting class, free releases
// a slot by key, access reports class, byte offset and chunk size.
// ---------------------------------------------------------------------------
`default_nettype none

module three_class_chunk_allocator_unit #(
  parameter int unsigned SMALL_CHUNKS  = cca_pkg::SMALL_CHUNKS_DEF,
  parameter int unsigned MEDIUM_CHUNKS = cca_pkg::MEDIUM_CHUNKS_DEF,
  parameter int unsigned LARGE_CHUNKS  = cca_pkg::LARGE_CHUNKS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // Input channel.
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [cca_pkg::MODE_W-1:0]       mode,
  input  wire  [cca_pkg::BYTES_W-1:0]      request_bytes,
  input  wire  [cca_pkg::KEY_W-1:0]        key,
  // Output channel.
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [cca_pkg::STATUS_W-1:0]     status,
  output logic [cca_pkg::KEY_W-1:0]        result_key,
  output logic [cca_pkg::CLASS_W-1:0]      chunk_class,
  output logic [cca_pkg::OFFSET_W-1:0]     byte_offset,
  output logic [cca_pkg::BYTES_W-1:0]      chunk_bytes,
  // Configuration channel.
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [cca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [cca_pkg::BYTES_W-1:0]      cfg_data
);

  localparam int unsigned CNT_W = cca_pkg::INDEX_W + 1;
  localparam int unsigned PROD_W = cca_pkg::INDEX_W + cca_pkg::BYTES_W;

  // Configuration registers.
  logic [cca_pkg::BYTES_W-1:0] small_bytes;
  logic [cca_pkg::BYTES_W-1:0] medium_bytes;
  logic [cca_pkg::BYTES_W-1:0] large_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_bytes  <= cca_pkg::SMALL_BYTES_RST;
      medium_bytes <= cca_pkg::MEDIUM_BYTES_RST;
      large_bytes  <= cca_pkg::LARGE_BYTES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cca_pkg::CFG_SMALL_BYTES:  small_bytes  <= cfg_data;
        cca_pkg::CFG_MEDIUM_BYTES: medium_bytes <= cfg_data;
        cca_pkg::CFG_LARGE_BYTES:  large_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                        s1_valid;
  logic [cca_pkg::MODE_W-1:0]  s1_mode;
  logic [cca_pkg::BYTES_W-1:0] s1_req;
  logic [cca_pkg::KEY_W-1:0]   s1_key;
  logic                        s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mode <= mode;
      s1_req  <= request_bytes;
      s1_key  <= key;
    end
  end

  // Occupancy maps, one per class.
  cca_pkg::pool_cmd_t  cmd_s, cmd_m, cmd_l;
  cca_pkg::pool_stat_t stat_s, stat_m, stat_l;

  cca_pool_map #(.CHUNKS(SMALL_CHUNKS)) u_map_small (
    .clk (clk), .rst (rst), .cmd (cmd_s), .stat (stat_s)
  );
  cca_pool_map #(.CHUNKS(MEDIUM_CHUNKS)) u_map_medium (
    .clk (clk), .rst (rst), .cmd (cmd_m), .stat (stat_m)
  );
  cca_pool_map #(.CHUNKS(LARGE_CHUNKS)) u_map_large (
    .clk (clk), .rst (rst), .cmd (cmd_l), .stat (stat_l)
  );

  // Smallest class whose chunk size fits the request.
  logic [cca_pkg::CLASS_W-1:0] fit_class;

  always_comb begin
    if (s1_req <= small_bytes) begin
      fit_class = cca_pkg::CLASS_SMALL;
    end else if (s1_req <= medium_bytes) begin
      fit_class = cca_pkg::CLASS_MEDIUM;
    end else if (s1_req <= large_bytes) begin
      fit_class = cca_pkg::CLASS_LARGE;
    end else begin
      fit_class = cca_pkg::CLASS_NONE;
    end
  end

  // Free slot and key bit of the fitting class.
  logic                        fit_free;
  logic [cca_pkg::INDEX_W-1:0] fit_idx;
  logic [cca_pkg::KEY_W-1:0]   fit_bit;

  always_comb begin
    case (fit_class)
      cca_pkg::CLASS_SMALL: begin
        fit_free = stat_s.any_free;
        fit_idx  = stat_s.free_idx;
        fit_bit  = cca_pkg::CLASS_BIT_S;
      end
      cca_pkg::CLASS_MEDIUM: begin
        fit_free = stat_m.any_free;
        fit_idx  = stat_m.free_idx;
        fit_bit  = cca_pkg::CLASS_BIT_M;
      end
      cca_pkg::CLASS_LARGE: begin
        fit_free = stat_l.any_free;
        fit_idx  = stat_l.free_idx;
        fit_bit  = cca_pkg::CLASS_BIT_L;
      end
      default: begin
        fit_free = 1'b0;
        fit_idx  = '0;
        fit_bit  = '0;
      end
    endcase
  end

  // Class and range check of the given key; the highest class bit wins.
  logic [cca_pkg::CLASS_W-1:0] key_class;
  logic [cca_pkg::INDEX_W-1:0] key_idx;
  logic                        key_in_range;

  assign key_idx = s1_key[cca_pkg::INDEX_W-1:0];

  always_comb begin
    if ((s1_key & cca_pkg::CLASS_BIT_S) != '0) begin
      key_class = cca_pkg::CLASS_SMALL;
    end else if ((s1_key & cca_pkg::CLASS_BIT_M) != '0) begin
      key_class = cca_pkg::CLASS_MEDIUM;
    end else if ((s1_key & cca_pkg::CLASS_BIT_L) != '0) begin
      key_class = cca_pkg::CLASS_LARGE;
    end else begin
      key_class = cca_pkg::CLASS_NONE;
    end
  end

  always_comb begin
    case (key_class)
      cca_pkg::CLASS_SMALL:  key_in_range = {1'b0, key_idx} < CNT_W'(SMALL_CHUNKS);
      cca_pkg::CLASS_MEDIUM: key_in_range = {1'b0, key_idx} < CNT_W'(MEDIUM_CHUNKS);
      cca_pkg::CLASS_LARGE:  key_in_range = {1'b0, key_idx} < CNT_W'(LARGE_CHUNKS);
      default:               key_in_range = 1'b0;
    endcase
  end

  // Operation decode.
  logic [cca_pkg::STATUS_W-1:0] st_next;
  logic [cca_pkg::KEY_W-1:0]    rkey_next;
  logic [cca_pkg::CLASS_W-1:0]  sel_class;
  logic [cca_pkg::INDEX_W-1:0]  sel_idx;
  logic                         do_claim;
  logic                         do_drop;

  always_comb begin
    st_next   = cca_pkg::STATUS_BAD_KEY;
    rkey_next = s1_key;
    sel_class = cca_pkg::CLASS_NONE;
    sel_idx   = '0;
    do_claim  = 1'b0;
    do_drop   = 1'b0;
    unique case (s1_mode) inside
      cca_pkg::MODE_RESERVE: begin
        rkey_next = cca_pkg::KEY_NULL;
        if (fit_class == cca_pkg::CLASS_NONE) begin
          st_next = cca_pkg::STATUS_TOO_LARGE;
        end else if (!fit_free) begin
          st_next = cca_pkg::STATUS_FULL;
        end else begin
          st_next   = cca_pkg::STATUS_OK;
          rkey_next = fit_bit | cca_pkg::KEY_W'(fit_idx);
          sel_class = fit_class;
          sel_idx   = fit_idx;
          do_claim  = 1'b1;
        end
      end
      cca_pkg::MODE_FREE, cca_pkg::MODE_ACCESS: begin
        if (s1_key != cca_pkg::KEY_NULL && key_in_range) begin
          st_next   = cca_pkg::STATUS_OK;
          sel_class = key_class;
          sel_idx   = key_idx;
          do_drop   = (s1_mode == cca_pkg::MODE_FREE);
        end
      end
      default: ;
    endcase
  end

  // Map commands, issued only when the beat moves to the output register.
  always_comb begin
    cmd_s.claim    = s1_fire && do_claim && sel_class == cca_pkg::CLASS_SMALL;
    cmd_m.claim    = s1_fire && do_claim && sel_class == cca_pkg::CLASS_MEDIUM;
    cmd_l.claim    = s1_fire && do_claim && sel_class == cca_pkg::CLASS_LARGE;
    cmd_s.drop     = s1_fire && do_drop && sel_class == cca_pkg::CLASS_SMALL;
    cmd_m.drop     = s1_fire && do_drop && sel_class == cca_pkg::CLASS_MEDIUM;
    cmd_l.drop     = s1_fire && do_drop && sel_class == cca_pkg::CLASS_LARGE;
    cmd_s.drop_idx = key_idx;
    cmd_m.drop_idx = key_idx;
    cmd_l.drop_idx = key_idx;
  end

  // Chunk size and byte offset of the selected slot.
  logic [cca_pkg::BYTES_W-1:0] sel_size;
  logic [PROD_W-1:0]           offset_prod;

  always_comb begin
    case (sel_class)
      cca_pkg::CLASS_SMALL:  sel_size = small_bytes;
      cca_pkg::CLASS_MEDIUM: sel_size = medium_bytes;
      cca_pkg::CLASS_LARGE:  sel_size = large_bytes;
      default:               sel_size = '0;
    endcase
  end

  assign offset_prod = PROD_W'(sel_idx) * PROD_W'(sel_size);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status      <= st_next;
      result_key  <= rkey_next;
      chunk_class <= sel_class;
      byte_offset <= offset_prod[cca_pkg::OFFSET_W-1:0];
      chunk_bytes <= sel_size;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cca_checker.sv @@
// ---------------------------------------------------------------------------
// Chunk allocator port checker
// Watches the top-level ports of the allocator and flags result beats that
// break the field rules or the output handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module cca_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [cca_pkg::STATUS_W-1:0]     status,
  input wire [cca_pkg::KEY_W-1:0]        result_key,
  input wire [cca_pkg::CLASS_W-1:0]      chunk_class,
  input wire [cca_pkg::OFFSET_W-1:0]     byte_offset,
  input wire [cca_pkg::BYTES_W-1:0]      chunk_bytes
);

  // A stalled result beat holds its key.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_key))
    else $error("result beat changed while stalled");

  // A failed beat carries no class, offset or size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cca_pkg::STATUS_OK |->
      chunk_class == cca_pkg::CLASS_NONE && byte_offset == '0 && chunk_bytes == '0)
    else $error("failed beat carries class data");

  // A successful beat always names a class.
  a_ok_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cca_pkg::STATUS_OK |-> chunk_class != cca_pkg::CLASS_NONE)
    else $error("successful beat has no class");

  // A failed reserve returns the null key.
  a_reserve_fail_null: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cca_pkg::STATUS_TOO_LARGE || status == cca_pkg::STATUS_FULL)
      |-> result_key == cca_pkg::KEY_NULL)
    else $error("failed reserve returned a key");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind three_class_chunk_allocator_unit cca_checker u_cca_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .result_key  (result_key),
  .chunk_class (chunk_class),
  .byte_offset (byte_offset),
  .chunk_bytes (chunk_bytes)
);

`default_nettype wire
